// ===== design/dqmq_pkg.sv =====
// dqmq_pkg: shared types and field widths for the deque with middle query
// no dependencies

package dqmq_pkg;

   localparam int ACTION_W = 3;
   localparam int ITEM_W   = 32;
   localparam int COUNT_W  = 7;

   typedef enum logic [ACTION_W-1:0] {
      ACT_PUSH_BACK  = 3'd0,
      ACT_PUSH_FRONT = 3'd1,
      ACT_POP_BACK   = 3'd2,
      ACT_POP_FRONT  = 3'd3,
      ACT_QUERY      = 3'd4
   } action_type;

   typedef struct packed {
      logic refused;
      logic bypass;
   } s1_flags_type;

endpackage

// ===== design/dqmq_ram.sv =====
// dqmq_ram: generic single write port, single read port ram with registered read
// no dependencies

module dqmq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/deque_with_middle_query_top.sv =====
// deque_with_middle_query_top: ring-based deque of signed values with middle element report
// depends on dqmq_pkg and dqmq_ram
//
// usage:
//  - req channel: one transaction carries an action (push back, push front,
//    pop back, pop front, query; codes 5 to 7 act as query) and a value
//  - rsp channel: one transaction per request with the element at offset
//    count/2 from the front after the action, its valid flag, the empty
//    flag, the element count (low 7 bits) and a flag for a push refused on
//    a full ring
//  - response path: the pointers and count are updated and the ram is read
//    at the accepting edge; the result register is loaded from the second
//    stage when the output register is free or being taken by the receiver
//  - throughput: one transaction per cycle while the receiver takes responses, set by the single ram read port
//  - reset: the deque is empty, both pipeline stages are cleared; the ring
//    contents are not cleared, only written entries are ever reported
//  - when the receiver stalls, the result stays in the output register, the
//    second stage holds, and req_ready drops once both stages are full

module deque_with_middle_query_top #(
   parameter int DEPTH = 64
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [dqmq_pkg::ACTION_W-1:0]          req_action,
   input  logic signed [dqmq_pkg::ITEM_W-1:0]     req_item_value,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [dqmq_pkg::ITEM_W-1:0]     rsp_middle_value,
   output logic                                   rsp_middle_valid,
   output logic                                   rsp_is_empty,
   output logic [dqmq_pkg::COUNT_W-1:0]           rsp_element_count,
   output logic                                   rsp_push_refused
);

   import dqmq_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic [AW-1:0]     front_ff, front_in;
   logic [CW-1:0]     count_ff, count_in;
   logic              s1_valid_ff;
   logic [CW-1:0]     s1_count_ff;
   s1_flags_type      s1_flags_ff, s1_flags_in;
   logic [ITEM_W-1:0] s1_byp_data_ff;
   logic              rsp_valid_ff;
   logic [ITEM_W-1:0] rsp_middle_value_ff, rsp_middle_value_in;
   logic              rsp_middle_valid_ff;
   logic              rsp_is_empty_ff;
   logic [COUNT_W-1:0] rsp_element_count_ff;
   logic              rsp_push_refused_ff;

   logic              accept, s1_adv, full, empty;
   logic              wr_en;
   logic              push_refused, rd_bypass;
   logic [AW-1:0]     wr_addr, rd_addr, back_addr, front_dec, front_inc;
   logic [AW:0]       back_sum, mid_sum;
   logic [ITEM_W-1:0] rd_data;

   assign full   = (count_ff == CW'(DEPTH));
   assign empty  = (count_ff == '0);
   assign s1_adv = !rsp_valid_ff || rsp_ready;
   assign req_ready = !s1_valid_ff || s1_adv;
   assign accept = req_valid && req_ready;

   // ring positions
   always_comb begin
      back_sum = {1'b0, front_ff} + (AW+1)'(count_ff);
      if (back_sum >= (AW+1)'(DEPTH)) begin
         back_sum = back_sum - (AW+1)'(DEPTH);
      end
      back_addr = back_sum[AW-1:0];
      front_dec = (front_ff == '0) ? AW'(DEPTH - 1) : front_ff - AW'(1);
      front_inc = (front_ff == AW'(DEPTH - 1)) ? '0 : front_ff + AW'(1);
   end

   // action decode
   always_comb begin
      front_in = front_ff;
      count_in = count_ff;
      wr_en    = 1'b0;
      wr_addr  = back_addr;
      push_refused = 1'b0;
      unique case (action_type'(req_action))
         ACT_PUSH_BACK: begin
            if (full) begin
               push_refused = 1'b1;
            end else begin
               wr_en    = accept;
               count_in = count_ff + CW'(1);
            end
         end
         ACT_PUSH_FRONT: begin
            wr_addr = front_dec;
            if (full) begin
               push_refused = 1'b1;
            end else begin
               wr_en    = accept;
               front_in = front_dec;
               count_in = count_ff + CW'(1);
            end
         end
         ACT_POP_BACK: begin
            if (!empty) begin
               count_in = count_ff - CW'(1);
            end
         end
         ACT_POP_FRONT: begin
            if (!empty) begin
               front_in = front_inc;
               count_in = count_ff - CW'(1);
            end
         end
         default: begin
         end
      endcase
   end

   // middle entry address after the action
   always_comb begin
      mid_sum = {1'b0, front_in} + (AW+1)'(count_in >> 1);
      if (mid_sum >= (AW+1)'(DEPTH)) begin
         mid_sum = mid_sum - (AW+1)'(DEPTH);
      end
      rd_addr = mid_sum[AW-1:0];
      rd_bypass = wr_en && (wr_addr == rd_addr);
   end

   assign s1_flags_in = '{refused: push_refused, bypass: rd_bypass};

   dqmq_ram #(
      .WIDTH (ITEM_W),
      .DEPTH (DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_item_value),
      .rd_en   (accept),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      if (s1_count_ff == '0) begin
         rsp_middle_value_in = '0;
      end else if (s1_flags_ff.bypass) begin
         rsp_middle_value_in = s1_byp_data_ff;
      end else begin
         rsp_middle_value_in = rd_data;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff     <= '0;
         count_ff     <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            front_ff <= front_in;
            count_ff <= count_in;
         end
         if (req_ready) begin
            s1_valid_ff <= accept;
         end
         if (s1_adv) begin
            rsp_valid_ff <= s1_valid_ff;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_count_ff    <= count_in;
         s1_flags_ff    <= s1_flags_in;
         s1_byp_data_ff <= req_item_value;
      end
      if (s1_adv && s1_valid_ff) begin
         rsp_middle_value_ff  <= rsp_middle_value_in;
         rsp_middle_valid_ff  <= (s1_count_ff != '0);
         rsp_is_empty_ff      <= (s1_count_ff == '0);
         rsp_element_count_ff <= COUNT_W'(s1_count_ff);
         rsp_push_refused_ff  <= s1_flags_ff.refused;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_middle_value  = rsp_middle_value_ff;
   assign rsp_middle_valid  = rsp_middle_valid_ff;
   assign rsp_is_empty      = rsp_is_empty_ff;
   assign rsp_element_count = rsp_element_count_ff;
   assign rsp_push_refused  = rsp_push_refused_ff;

endmodule
